// ===== src/dfs_pkg.sv =====
// Package for the five-point diffusion stencil: field widths, register
// map, reset values and the word types shared by the stencil modules.
// Depends on nothing.
`timescale 1ns / 1ps

package dfs_pkg;

    localparam int VALUE_W  = 32;
    localparam int FAC_W    = 16;
    localparam int GW_W     = 11;
    localparam int GH_W     = 16;
    localparam int LAP_W    = VALUE_W + 3;
    localparam int PROD_W   = LAP_W + FAC_W + 1;
    localparam int FRAC_W   = 16;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [FAC_W-1:0] STEP_FACTOR_RST = 16'd16384;
    localparam logic [GW_W-1:0]  GRID_WIDTH_RST  = 11'd1024;
    localparam logic [GH_W-1:0]  GRID_HEIGHT_RST = 16'd1024;
    localparam int               MIN_GRID        = 3;

    typedef enum logic [1:0] {
        REG_STEP_FACTOR = 2'd0,
        REG_GRID_WIDTH  = 2'd1,
        REG_GRID_HEIGHT = 2'd2
    } dfs_reg_idx_t;

    // One column of the 3x3 window: row above, middle row, row below.
    typedef struct packed {
        logic signed [VALUE_W-1:0] top;
        logic signed [VALUE_W-1:0] mid;
        logic signed [VALUE_W-1:0] bot;
    } dfs_col_t;

    // One result word.
    typedef struct packed {
        logic signed [VALUE_W-1:0] new_value;
        logic                      frame_last;
    } dfs_result_t;

endpackage

// ===== src/dfs_if.sv =====
// Stream interfaces for the stencil: grid cell words in, result words out.
// Depends on dfs_pkg.
`timescale 1ns / 1ps

interface dfs_in_if import dfs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface dfs_out_if import dfs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] new_value;
    logic                      frame_last;

    modport source (output valid, output new_value, output frame_last, input ready);
    modport sink   (input valid, input new_value, input frame_last, output ready);
endinterface

// ===== src/dfs_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Depends on nothing.
`timescale 1ns / 1ps

module dfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dfs_window_cell.sv =====
// One column cell of the stencil window; cells chain so that each column
// moves one place west per accepted word. Depends on dfs_pkg.
`timescale 1ns / 1ps

module dfs_window_cell import dfs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     shift,
    input  dfs_col_t col_in,
    output dfs_col_t col_out
);

    dfs_col_t col_reg;
    dfs_col_t col_next;

    // hold unless a word moves through
    always_comb
    begin
        col_next = shift ? col_in : col_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

// ===== src/dfs_out_queue.sv =====
// Result queue decoupling the stencil pipeline from the output handshake.
// Depends on dfs_pkg.
`timescale 1ns / 1ps

module dfs_out_queue import dfs_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  dfs_result_t                push_word,
    input  logic                       ready,
    output logic                       valid,
    output dfs_result_t                head_word,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dfs_result_t      store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign valid     = (count_reg != '0);
    assign pop       = valid && ready;
    assign head_word = store[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== src/diffusion_five_point_stencil.sv =====
// Five-point diffusion stencil, top level: counters, line stores, window chain,
// arithmetic pipeline, APB registers. Depends on dfs_pkg, dfs_if, dfs_ram,
// dfs_window_cell and dfs_out_queue.
`timescale 1ns / 1ps

// One forward-Euler step of 2D diffusion on a grid streamed in raster order,
// ghost border included, one 32-bit Q2.30 word per cell. For every interior
// cell the block returns c + fac*(n+s+e+w-4c), floor-shifted by 16 and
// saturated, in raster order; frame_last marks the last interior cell. Border
// cells feed the stencil and give no result. The block takes one cell word
// per clock while credits remain: each line store has one read and one write
// port, and each word reads and rewrites one entry of both. A result passes
// through stages 1 to 4 and the result queue before it is offered on
// result_out. Words in the pipeline and in the eight-word result queue share
// eight credits; cell_in.ready falls when they are used up, so with
// result_out.ready held high the rate is one word per cycle.
// Write step_factor (Q0.16), grid_width and grid_height only while no word is
// in flight; a write mid-frame takes effect at once and keeps the raster
// counters, which wrap at the new bounds after the current cell.
// grid_width below 3 acts as 3, above MAX_WIDTH as MAX_WIDTH; grid_height
// below 3 acts as 3. The line stores need no clearing pass after reset.
module diffusion_five_point_stencil import dfs_pkg::*; #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    dfs_in_if.sink             cell_in,
    dfs_out_if.source          result_out
);

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WCMP_RAW    = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_W      = (WCMP_RAW > GW_W) ? WCMP_RAW : GW_W;
    localparam int QUEUE_DEPTH = 8;
    localparam int PIPE_STAGES = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = $clog2(QUEUE_DEPTH + PIPE_STAGES + 1);
    localparam int SUM_W       = PROD_W - FRAC_W + 1;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [FAC_W-1:0] step_factor_reg, step_factor_next;
    logic [GW_W-1:0]  grid_width_reg,  grid_width_next;
    logic [GH_W-1:0]  grid_height_reg, grid_height_next;
    logic             cfg_write;
    dfs_reg_idx_t     cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = dfs_reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        step_factor_next = step_factor_reg;
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg_write)
        begin
            case (cfg_idx)
                REG_STEP_FACTOR: step_factor_next = pwdata[FAC_W-1:0];
                REG_GRID_WIDTH:  grid_width_next  = pwdata[GW_W-1:0];
                REG_GRID_HEIGHT: grid_height_next = pwdata[GH_W-1:0];
                default:         step_factor_next = step_factor_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_STEP_FACTOR: prdata = APB_DW'(step_factor_reg);
            REG_GRID_WIDTH:  prdata = APB_DW'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = APB_DW'(grid_height_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_factor_reg <= STEP_FACTOR_RST;
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end
        else
        begin
            step_factor_reg <= step_factor_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: accept, raster counters, line store read
    // ---------------------------------------------------------------
    logic                    accept;
    logic [WCMP_W-1:0]       gw_ext, eff_w, col_plus;
    logic [GH_W-1:0]         eff_h;
    logic [GH_W:0]           row_plus;
    logic                    row_end, frame_end, emit;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [GH_W-1:0]         row_reg, row_next;
    logic [QCNT_W-1:0]       q_count;
    logic [OCC_W-1:0]        inflight, occupancy;

    // clamp the grid shape to what the line stores can hold
    always_comb
    begin
        gw_ext = WCMP_W'(grid_width_reg);
        if (gw_ext < WCMP_W'(MIN_GRID))
        begin
            eff_w = WCMP_W'(MIN_GRID);
        end
        else if (gw_ext > WCMP_W'(MAX_WIDTH))
        begin
            eff_w = WCMP_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = gw_ext;
        end
        eff_h = (grid_height_reg < GH_W'(MIN_GRID)) ? GH_W'(MIN_GRID) : grid_height_reg;
    end

    assign col_plus  = WCMP_W'(col_reg) + WCMP_W'(1);
    assign row_plus  = {1'b0, row_reg} + (GH_W+1)'(1);
    assign row_end   = (col_plus >= eff_w);
    assign frame_end = row_end && (row_plus >= {1'b0, eff_h});
    // the window is centred one row up and one column left of the new cell
    assign emit      = (row_reg >= GH_W'(2)) && (col_reg >= COL_W'(2));

    // credits: queue words plus every word still in the pipeline
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    assign inflight  = OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg)
                     + OCC_W'(s3_valid_reg) + OCC_W'(s4_valid_reg);
    assign occupancy = OCC_W'(q_count) + inflight;

    assign cell_in.ready = (occupancy < OCC_W'(QUEUE_DEPTH));
    assign accept        = cell_in.valid && cell_in.ready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = frame_end ? '0 : row_plus[GH_W-1:0];
            end
            else
            begin
                col_next = col_plus[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: line store data arrives; rotate stores, shift window
    // ---------------------------------------------------------------
    logic                      s1_emit_reg, s1_last_reg;
    logic [COL_W-1:0]          s1_addr_reg;
    logic signed [VALUE_W-1:0] s1_cell_reg;
    logic [VALUE_W-1:0]        upper_rd, lower_rd;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= emit;
            s1_last_reg <= frame_end;
            s1_addr_reg <= col_reg;
            s1_cell_reg <= cell_in.cell_value;
        end
    end

    // upper takes the old lower row, lower takes the new cell
    dfs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store_upper (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (lower_rd),
        .re    (accept),
        .raddr (col_reg),
        .rdata (upper_rd)
    );

    dfs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store_lower (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (s1_cell_reg),
        .re    (accept),
        .raddr (col_reg),
        .rdata (lower_rd)
    );

    // window chain: index 2 is the east column, 0 the west
    dfs_col_t win_in  [3];
    dfs_col_t win_col [3];

    assign win_in[2].top = $signed(upper_rd);
    assign win_in[2].mid = $signed(lower_rd);
    assign win_in[2].bot = s1_cell_reg;
    assign win_in[1]     = win_col[2];
    assign win_in[0]     = win_col[1];

    for (genvar g = 0; g < 3; g++)
    begin : g_window
        dfs_window_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .shift   (s1_valid_reg),
            .col_in  (win_in[g]),
            .col_out (win_col[g])
        );
    end

    // ---------------------------------------------------------------
    // Stage 2: Laplacian from the settled window
    // ---------------------------------------------------------------
    logic                      s2_emit_reg, s2_last_reg;
    logic signed [LAP_W-1:0]   lap_next;

    always_ff @(posedge clk)
    begin
        s2_emit_reg <= s1_emit_reg;
        s2_last_reg <= s1_last_reg;
    end

    always_comb
    begin
        lap_next = LAP_W'(win_col[1].top) + LAP_W'(win_col[1].bot)
                 + LAP_W'(win_col[0].mid) + LAP_W'(win_col[2].mid)
                 - (LAP_W'(win_col[1].mid) <<< 2);
    end

    // ---------------------------------------------------------------
    // Stage 3: scale by the step factor
    // ---------------------------------------------------------------
    logic                      s3_emit_reg, s3_last_reg;
    logic signed [LAP_W-1:0]   s3_lap_reg;
    logic signed [VALUE_W-1:0] s3_ctr_reg;
    logic signed [FAC_W:0]     fac_s;
    logic signed [PROD_W-1:0]  prod_next;

    always_ff @(posedge clk)
    begin
        s3_emit_reg <= s2_emit_reg;
        s3_last_reg <= s2_last_reg;
        s3_lap_reg  <= lap_next;
        s3_ctr_reg  <= win_col[1].mid;
    end

    assign fac_s     = $signed({1'b0, step_factor_reg});
    assign prod_next = s3_lap_reg * fac_s;

    // ---------------------------------------------------------------
    // Stage 4: floor shift, add centre, saturate, push
    // ---------------------------------------------------------------
    logic                      s4_emit_reg, s4_last_reg;
    logic signed [PROD_W-1:0]  s4_prod_reg;
    logic signed [VALUE_W-1:0] s4_ctr_reg;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_W-1:0] sat_value;
    logic                      q_push;
    dfs_result_t               q_word, q_head;

    always_ff @(posedge clk)
    begin
        s4_emit_reg <= s3_emit_reg;
        s4_last_reg <= s3_last_reg;
        s4_prod_reg <= prod_next;
        s4_ctr_reg  <= s3_ctr_reg;
    end

    // dropping the low fraction bits of a signed value rounds toward minus infinity
    assign sum = SUM_W'(s4_ctr_reg) + SUM_W'($signed(s4_prod_reg[PROD_W-1:FRAC_W]));

    always_comb
    begin
        if (sum > SUM_W'(signed'({1'b0, {(VALUE_W-1){1'b1}}})))
        begin
            sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (sum < -(SUM_W'(signed'({1'b0, 1'b1, {(VALUE_W-1){1'b0}}}))))
        begin
            sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat_value = sum[VALUE_W-1:0];
        end
    end

    assign q_push            = s4_valid_reg && s4_emit_reg;
    assign q_word.new_value  = sat_value;
    assign q_word.frame_last = s4_last_reg;

    dfs_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_word),
        .ready     (result_out.ready),
        .valid     (result_out.valid),
        .head_word (q_head),
        .count     (q_count)
    );

    assign result_out.new_value  = q_head.new_value;
    assign result_out.frame_last = q_head.frame_last;

    // advance the valid chain every cycle; the stages never stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= OCC_W'(QUEUE_DEPTH))
        else $error("pipeline and result queue hold more words than the queue depth");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg && (s1_addr_reg == $past(col_reg)))
        else $error("accepted cell word did not enter stage 1 at its column");

    a_last_is_interior: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_last_reg) |-> s4_emit_reg)
        else $error("frame end marked on a border cell");

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !(result_out.valid && result_out.ready)) |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("result pushed into a full queue");

endmodule

// ===== dv/diffusion_five_point_stencil_tb.sv =====
// Self-checking testbench for diffusion_five_point_stencil: APB set-up, a
// directed probe of clamped grid sizes and saturation, random grids, then a
// closing mid-sized grid. Depends on dfs_pkg, dfs_if and the stencil RTL.
`timescale 1ns / 1ps

module diffusion_five_point_stencil_tb;
    import dfs_pkg::*;

    localparam int MAX_W           = 1024;
    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int RANDOM_WORDS    = 480;
    localparam int CLOSE_WIDTH     = 40;
    localparam int CLOSE_HEIGHT    = 5;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int WATCHDOG_LIMIT  = 2000;

    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint VALUE_MIN = -64'sd2147483648;

    // One 3x3 probe frame: raw register values, the three kinds of cell in
    // it and the single result it must give.
    typedef struct packed {
        logic [GW_W-1:0]           width_raw;
        logic [GH_W-1:0]           height_raw;
        logic [FAC_W-1:0]          fac;
        logic signed [VALUE_W-1:0] corner;
        logic signed [VALUE_W-1:0] side;
        logic signed [VALUE_W-1:0] centre;
        logic signed [VALUE_W-1:0] want;
    } probe_frame_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    dfs_in_if  cell_in_bus ();
    dfs_out_if result_bus ();

    diffusion_five_point_stencil #(
        .MAX_WIDTH (MAX_W)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cell_in    (cell_in_bus),
        .result_out (result_bus)
    );

    // Predictor state: its own line stores, window, raster position and
    // register mirror, advanced once per accepted cell word.
    logic signed [VALUE_W-1:0] upper_line [MAX_W];
    logic signed [VALUE_W-1:0] lower_line [MAX_W];
    logic signed [VALUE_W-1:0] win [3][3];
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [FAC_W-1:0]          cur_fac;
    logic [GW_W-1:0]           cur_width;
    logic [GH_W-1:0]           cur_height;

    // Results still owed by the block, oldest first.
    dfs_result_t pending_results [$];

    int idle_pct      = 0;
    int stall_asks    = 0;
    int stall_served  = 0;
    int mismatches    = 0;
    int words_in      = 0;
    int words_out     = 0;
    int saturated     = 0;
    int settings_used = 0;
    int quiet_cycles  = 0;

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int unsigned eff_width(input logic [GW_W-1:0] raw);
        if (raw < MIN_GRID)
            return MIN_GRID;
        if (raw > MAX_W)
            return MAX_W;
        return raw;
    endfunction

    function automatic int unsigned eff_height(input logic [GH_W-1:0] raw);
        return (raw < MIN_GRID) ? MIN_GRID : raw;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // Advance the predictor by one cell word; hand back the result it causes.
    task automatic predict_cell(input logic signed [VALUE_W-1:0] word,
                                output bit produced, output dfs_result_t res);
        int unsigned               w_eff;
        int unsigned               h_eff;
        logic signed [VALUE_W-1:0] above;
        logic signed [VALUE_W-1:0] below;
        bit                        row_end;
        bit                        frame_end;
        longint                    lap;
        longint                    sum;
        int                        k;
        w_eff     = eff_width(cur_width);
        h_eff     = eff_height(cur_height);
        row_end   = (col_pos + 1 >= w_eff);
        frame_end = row_end && (row_pos + 1 >= h_eff);
        produced  = 1'b0;
        res       = '0;

        above               = upper_line[col_pos];
        below               = lower_line[col_pos];
        upper_line[col_pos] = below;
        lower_line[col_pos] = word;

        for (k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = above;
        win[1][2] = below;
        win[2][2] = word;

        // Centre of the window sits one row up and one column left.
        if (row_pos >= 2 && col_pos >= 2)
        begin
            lap = longint'(win[0][1]) + longint'(win[2][1])
                + longint'(win[1][0]) + longint'(win[1][2])
                - 4 * longint'(win[1][1]);
            sum = longint'(win[1][1]) + ((lap * longint'(cur_fac)) >>> FRAC_W);
            if (sum > VALUE_MAX || sum < VALUE_MIN)
                saturated++;
            if (sum > VALUE_MAX)
                sum = VALUE_MAX;
            else if (sum < VALUE_MIN)
                sum = VALUE_MIN;
            res.new_value  = sum[VALUE_W-1:0];
            res.frame_last = frame_end;
            produced       = 1'b1;
        end

        if (row_end)
        begin
            col_pos = 0;
            row_pos = frame_end ? 0 : ((row_pos + 1) & 32'hFFFF);
        end
        else
            col_pos = col_pos + 1;
    endtask

    task automatic apb_write(input dfs_reg_idx_t idx, input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_STEP_FACTOR: cur_fac    = data[FAC_W-1:0];
            REG_GRID_WIDTH:  cur_width  = data[GW_W-1:0];
            REG_GRID_HEIGHT: cur_height = data[GH_W-1:0];
            default:         ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input dfs_reg_idx_t idx, output logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'({idx, 2'b00});
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input dfs_reg_idx_t idx, input logic [APB_DW-1:0] want);
        logic [APB_DW-1:0] got;
        apb_read(idx, got);
        if (got !== want)
            report_mismatch($sformatf("register %s reads %h, want %h",
                                      idx.name(), got, want));
    endtask

    // Drop valid, wait for every owed result, then let the pipeline empty
    // of border words that give no result.
    task automatic drain_results();
        @(negedge clk);
        cell_in_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Reprogram the grid between frames only, and read every register back.
    task automatic set_grid(input logic [GW_W-1:0] width_raw,
                            input logic [GH_W-1:0] height_raw,
                            input logic [FAC_W-1:0] fac);
        drain_results();
        apb_write(REG_STEP_FACTOR, APB_DW'(fac));
        apb_write(REG_GRID_WIDTH, APB_DW'(width_raw));
        apb_write(REG_GRID_HEIGHT, APB_DW'(height_raw));
        check_reg(REG_STEP_FACTOR, APB_DW'(fac));
        check_reg(REG_GRID_WIDTH, APB_DW'(width_raw));
        check_reg(REG_GRID_HEIGHT, APB_DW'(height_raw));
        settings_used++;
    endtask

    // Offer one cell word, with an optional idle burst ahead of it; hold it
    // until the block takes it, then queue what the predictor owes.
    task automatic push_cell(input logic signed [VALUE_W-1:0] word, input bit typed,
                             input dfs_result_t typed_want);
        bit          produced;
        dfs_result_t res;
        int          gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            cell_in_bus.valid <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        cell_in_bus.valid      <= 1'b1;
        cell_in_bus.cell_value <= word;
        @(posedge clk);
        while (!cell_in_bus.ready)
            @(posedge clk);
        predict_cell(word, produced, res);
        if (produced)
            pending_results.push_back(typed ? typed_want : res);
        words_in++;
    endtask

    // Mostly a smooth field around a base level, with full-range noise and
    // the extremes mixed in.
    function automatic logic signed [VALUE_W-1:0] pick_word(
        input logic signed [VALUE_W-1:0] base, input int unsigned spread);
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh7FFFFFFF;
                    1:       v = 32'sh80000000;
                    2:       v = '0;
                    default: v = -32'sd1;
                endcase
            end
            1, 2:    v = $urandom;
            default: v = base + VALUE_W'($urandom_range(0, 2 * spread)) - VALUE_W'(spread);
        endcase
        return v;
    endfunction

    // Receiver: random idle bursts, plus a long hold-off on request so that
    // the result queue fills and the block stalls its input.
    initial
    begin : result_sink
        int gap_left;
        gap_left         = 0;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_served != stall_asks)
            begin
                stall_served = stall_asks;
                result_bus.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1)
                    @(negedge clk);
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                result_bus.ready <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                gap_left = $urandom_range(1, 3) - 1;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= 1'b1;
        end
    end

    // Compare each result word with the oldest one owed, field by field.
    always @(posedge clk)
    begin : result_check
        dfs_result_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            words_out++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result word %h/%b with nothing owed",
                                          result_bus.new_value, result_bus.frame_last));
            else
            begin
                want = pending_results.pop_front();
                if (result_bus.new_value !== want.new_value)
                    report_mismatch($sformatf("result %0d new_value %h, want %h", words_out,
                                              result_bus.new_value, want.new_value));
                if (result_bus.frame_last !== want.frame_last)
                    report_mismatch($sformatf("result %0d frame_last %b, want %b", words_out,
                                              result_bus.frame_last, want.frame_last));
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((cell_in_bus.valid && cell_in_bus.ready)
                || (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        probe_frame_t              probe_frames [3];
        dfs_result_t               typed_want;
        dfs_result_t               no_want;
        logic signed [VALUE_W-1:0] word;
        logic signed [VALUE_W-1:0] base;
        logic [GW_W-1:0]           width_raw;
        logic [GH_W-1:0]           height_raw;
        logic [FAC_W-1:0]          fac;
        int unsigned               spread;
        int unsigned               frame_words;
        int                        phase;
        int                        random_words;
        int                        f;
        int                        k;

        // Hold every input at a known value from time zero.
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        cell_in_bus.valid      = 1'b0;
        cell_in_bus.cell_value = '0;
        no_want                = '0;

        // Predictor starts where the block does after reset.
        for (k = 0; k < MAX_W; k++)
        begin
            upper_line[k] = '0;
            lower_line[k] = '0;
        end
        for (k = 0; k < 9; k++)
            win[k / 3][k % 3] = '0;
        col_pos    = 0;
        row_pos    = 0;
        cur_fac    = STEP_FACTOR_RST;
        cur_width  = GRID_WIDTH_RST;
        cur_height = GRID_HEIGHT_RST;

        // Probe frames: every raw size below the minimum must act as 3x3, so
        // each frame gives one result on its ninth word, marked last.
        // Zero factor passes the centre through; full factor against extreme
        // neighbours must saturate upwards, then downwards.
        probe_frames[0] = '{11'd0, 16'd2, 16'd0,
                            32'hFFFFFFFF, 32'h7FFFFFFF, 32'h40000000, 32'h40000000};
        probe_frames[1] = '{11'd1, 16'd0, 16'hFFFF,
                            32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
        probe_frames[2] = '{11'd2, 16'd1, 16'hFFFF,
                            32'h55555555, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};

        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Registers must read back their reset values.
        check_reg(REG_STEP_FACTOR, APB_DW'(STEP_FACTOR_RST));
        check_reg(REG_GRID_WIDTH, APB_DW'(GRID_WIDTH_RST));
        check_reg(REG_GRID_HEIGHT, APB_DW'(GRID_HEIGHT_RST));

        // Directed part: walk the probe table, nine raster words per frame.
        idle_pct = 25;
        for (f = 0; f < 3; f++)
        begin
            set_grid(probe_frames[f].width_raw, probe_frames[f].height_raw,
                     probe_frames[f].fac);
            typed_want.new_value  = probe_frames[f].want;
            typed_want.frame_last = 1'b1;
            for (k = 0; k < 9; k++)
            begin
                if (k == 4)
                    word = probe_frames[f].centre;
                else if (k % 2 == 1)
                    word = probe_frames[f].side;
                else
                    word = probe_frames[f].corner;
                push_cell(word, 1'b1, typed_want);
            end
        end

        // Random part: small grids, whole frames, a fresh setting per phase.
        // Two phases use a grid tall and wide enough to fill the result
        // queue, and ask the receiver for a long hold-off as row two begins.
        phase        = 0;
        random_words = 0;
        while (random_words < RANDOM_WORDS)
        begin
            width_raw  = GW_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                           : $urandom_range(3, 14));
            height_raw = GH_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                           : $urandom_range(3, 8));
            if (phase == 1 || phase == 4)
            begin
                width_raw  = GW_W'($urandom_range(8, 14));
                height_raw = GH_W'($urandom_range(6, 8));
            end
            case ($urandom_range(0, 5))
                0:       fac = '0;
                1:       fac = 16'hFFFF;
                2:       fac = STEP_FACTOR_RST;
                default: fac = FAC_W'($urandom_range(1, 16384));
            endcase
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 15;
                default: idle_pct = 35;
            endcase
            set_grid(width_raw, height_raw, fac);
            frame_words = eff_width(width_raw) * eff_height(height_raw)
                        * $urandom_range(1, 3);
            base   = $urandom;
            spread = 1 << $urandom_range(4, 24);
            for (k = 0; k < frame_words; k++)
            begin
                if ((phase == 1 || phase == 4) && k == 2 * eff_width(width_raw))
                    stall_asks++;
                push_cell(pick_word(base, spread), 1'b0, no_want);
            end
            random_words += frame_words;
            phase++;
        end

        // Closing part, no idling: one whole frame of a mid-sized grid.
        idle_pct = 0;
        set_grid(GW_W'(CLOSE_WIDTH), GH_W'(CLOSE_HEIGHT), FAC_W'($urandom_range(0, 16384)));
        base   = $urandom;
        spread = 1 << 20;
        for (k = 0; k < CLOSE_WIDTH * CLOSE_HEIGHT; k++)
            push_cell(pick_word(base, spread), 1'b0, no_want);

        drain_results();

        $display("covered %0d cell words and %0d result words over %0d grid settings",
                 words_in, words_out, settings_used);
        $display("including %0d saturated results; %0d mismatches", saturated, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
